FILE: design/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants and the control word between the top level and the
// divide / square-root unit of the price series statistics block.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int unsigned MAX_ROWS_DEF   = 4096;
	localparam int unsigned PRICE_BITS_DEF = 32;
	localparam int unsigned OUT_BITS       = 32;
	localparam int unsigned COUNT_BITS     = 13;

	// Start request, busy and result-ready status of the arithmetic unit
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} pss_ctl_t;

endpackage

FILE: design/pss_divsqrt.sv
// ----------------------------------------------------------------------------
// pss_divsqrt
// Divides a wide sum by the row count with a restoring divider, one quotient
// bit a cycle, then takes the floor square root one result bit a cycle.
// ----------------------------------------------------------------------------
module pss_divsqrt
	import pss_pkg::*;
#(
	parameter int unsigned NUM_BITS = 128,
	parameter int unsigned DEN_BITS = 17,
	parameter int unsigned ROOT_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_BITS-1:0]  num,
	input  logic [DEN_BITS-1:0]  den,
	output pss_ctl_t             ctl,
	output logic [ROOT_BITS-1:0] root
);

	localparam int unsigned CW = $clog2(NUM_BITS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [ROOT_BITS+1:0] srem_q;

	logic [DEN_BITS:0]     rem_sh;
	logic [ROOT_BITS+1:0]  srem_sh;
	logic [ROOT_BITS+1:0]  strial;
	logic                  sq_ok;
	logic [ROOT_BITS-1:0]  root_next;

	assign rem_sh    = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};
	// digit-by-digit root: bring down two radicand bits, try root*4 + 1
	assign srem_sh   = {srem_q[ROOT_BITS-1:0], quo_q[NUM_BITS-1:NUM_BITS-2]};
	assign strial    = {root_q, 2'b01};
	assign sq_ok     = (srem_sh >= strial);
	assign root_next = {root_q[ROOT_BITS-2:0], sq_ok};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						cnt_q   <= CW'(NUM_BITS - 1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= CW'(ROOT_BITS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) state_q <= ST_IDLE;
					else cnt_q <= cnt_q - 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			quo_q  <= num;
			rem_q  <= '0;
			root_q <= '0;
			srem_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (rem_sh >= {1'b0, den}) begin
				rem_q <= rem_sh - {1'b0, den};
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end else if (state_q == ST_SQRT) begin
			quo_q  <= {quo_q[NUM_BITS-3:0], 2'b00};
			root_q <= root_next;
			if (sq_ok) srem_q <= srem_sh - strial;
			else srem_q <= srem_sh;
		end
	end

	always_comb begin
		ctl.start = start;
		ctl.busy  = (state_q != ST_IDLE);
		ctl.done  = (state_q == ST_SQRT) && (cnt_q == '0);
	end

	assign root = (state_q == ST_SQRT) ? root_next : root_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> !ctl.busy) else $error("unit stays busy after done");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q <= {1'b0, den})) else $error("remainder too large");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_DIV)) else $error("start lost");

endmodule

FILE: design/price_series_statistics.sv
// ----------------------------------------------------------------------------
// price_series_statistics
// Mean, max high, min low and population standard deviation of a price series.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one price row per word:
//    high, low, close (unsigned Q16.16) and last_row.
//  - Rows that are not last are taken one per cycle unless a result is being
//    computed; each close is written to a close memory; sum, max, min update.
//  - A last row starts the result: the mean (a restoring divide of the sum
//    over the count), then a pass over the close memory (one read a cycle,
//    then the pipeline drain), then the variance divide and the bit-serial
//    square root, and then the output register is loaded.
//  - Result channel (out_valid/out_ready) carries one word per series and
//    holds it until taken; a new series' rows are accepted meanwhile, but a
//    second last row waits until the output register is free.
//  - Reset clears the counters, sum, max and min; the memory needs no clear.
//  - Rows past MAX_ROWS are dropped and flag overflow.
// ----------------------------------------------------------------------------
module price_series_statistics
	import pss_pkg::*;
#(
	parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
	parameter int unsigned PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PRICE_BITS-1:0] high_price,
	input  logic [PRICE_BITS-1:0] low_price,
	input  logic [PRICE_BITS-1:0] close_price,
	input  logic                  last_row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_BITS-1:0]   mean_close,
	output logic [OUT_BITS-1:0]   max_high,
	output logic [OUT_BITS-1:0]   min_low,
	output logic [OUT_BITS-1:0]   std_dev,
	output logic [COUNT_BITS-1:0] row_count,
	output logic                  overflow
);

	localparam int unsigned AW       = $clog2(MAX_ROWS);
	localparam int unsigned NW       = $clog2(MAX_ROWS + 1);
	localparam int unsigned SUM_BITS = PRICE_BITS + NW;
	localparam int unsigned ACC_BITS = 2 * PRICE_BITS + NW;
	localparam int unsigned VAR_BITS = 128;
	localparam int unsigned SC_BITS  = $clog2(SUM_BITS + 1);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_PASS = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]            state_q;
	logic [NW-1:0]         rows_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [PRICE_BITS-1:0] max_q, min_q;
	logic                  drop_q;

	// close memory
	logic [PRICE_BITS-1:0] mem [MAX_ROWS];
	logic [PRICE_BITS-1:0] rd_s1;
	logic [NW-1:0]         rd_idx_q;
	logic                  rd_v_s1;

	// mean divider
	logic [SC_BITS-1:0]    mc_q;
	logic [SUM_BITS-1:0]   mq_q;
	logic [NW:0]           mr_q;
	logic [NW:0]           mr_sh;

	// squared deviation pipeline
	logic [PRICE_BITS-1:0]   dev_s2;
	logic                    dev_v_s2;
	logic [2*PRICE_BITS-1:0] sq_s3;
	logic                    sq_v_s3;
	logic [ACC_BITS-1:0]     acc_q;
	logic [PRICE_BITS-1:0]   mean_q;

	pss_ctl_t      ctl;
	logic          ds_start;
	logic [63:0]   root;

	logic          in_acc, take, out_acc;

	assign in_ready = (state_q == ST_LOAD) && !(last_row && out_valid);
	assign in_acc   = in_valid && in_ready;
	assign take     = in_acc && (rows_q < NW'(MAX_ROWS));
	assign out_acc  = out_valid && out_ready;
	assign mr_sh    = {mr_q[NW-1:0], mq_q[SUM_BITS-1]};

	always_ff @(posedge clk) begin
		if (take) mem[rows_q[AW-1:0]] <= close_price;
		rd_s1 <= mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			rows_q   <= '0;
			sum_q    <= '0;
			max_q    <= '0;
			min_q    <= '1;
			drop_q   <= 1'b0;
			out_valid <= 1'b0;
			rd_v_s1  <= 1'b0;
			dev_v_s2 <= 1'b0;
			sq_v_s3  <= 1'b0;
			rd_idx_q <= '0;
			mc_q     <= '0;
		end else begin
			if (out_acc) out_valid <= 1'b0;
			rd_v_s1  <= 1'b0;
			dev_v_s2 <= rd_v_s1;
			sq_v_s3  <= dev_v_s2;
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						rows_q <= rows_q + 1'b1;
						sum_q  <= sum_q + SUM_BITS'(close_price);
						if (high_price > max_q) max_q <= high_price;
						if (low_price < min_q) min_q <= low_price;
					end else if (in_acc) begin
						drop_q <= 1'b1;
					end
					if (in_acc && last_row) begin
						state_q <= ST_MEAN;
						mc_q    <= SC_BITS'(SUM_BITS);
					end
				end
				ST_MEAN: begin
					// advance the mean divide one bit a cycle
					if (mc_q == '0) begin
						state_q  <= ST_PASS;
						rd_idx_q <= '0;
					end else begin
						mc_q <= mc_q - 1'b1;
					end
				end
				ST_PASS: begin
					// issue one read a cycle, then drain the pipeline
					if (rd_idx_q < rows_q) begin
						rd_v_s1  <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_v_s1 && !dev_v_s2 && !sq_v_s3) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (ctl.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					rows_q    <= '0;
					sum_q     <= '0;
					max_q     <= '0;
					min_q     <= '1;
					drop_q    <= 1'b0;
					state_q   <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// mean datapath and variance accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			mq_q  <= in_acc ? (sum_q + (take ? SUM_BITS'(close_price) : '0)) : sum_q;
			mr_q  <= '0;
			acc_q <= '0;
		end else if (state_q == ST_MEAN && mc_q != '0) begin
			if (rows_q != '0 && mr_sh >= {1'b0, rows_q}) begin
				mr_q <= mr_sh - {1'b0, rows_q};
				mq_q <= {mq_q[SUM_BITS-2:0], 1'b1};
			end else begin
				mr_q <= mr_sh;
				mq_q <= {mq_q[SUM_BITS-2:0], 1'b0};
			end
		end else if (state_q == ST_MEAN) begin
			// a zero count cannot occur after a taken row; guard anyway
			mean_q <= (rows_q == '0) ? '0 : mq_q[PRICE_BITS-1:0];
		end
		if (sq_v_s3) acc_q <= acc_q + ACC_BITS'(sq_s3);
		dev_s2 <= (rd_s1 >= mean_q) ? rd_s1 - mean_q : mean_q - rd_s1;
		sq_s3  <= dev_s2 * dev_s2;
	end

	assign ds_start = (state_q == ST_PASS) && (rd_idx_q >= rows_q) &&
		!rd_v_s1 && !dev_v_s2 && !sq_v_s3;

	pss_divsqrt #(
		.NUM_BITS (VAR_BITS),
		.DEN_BITS (NW),
		.ROOT_BITS(64)
	) u_divsqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ds_start),
		.num   (VAR_BITS'(acc_q)),
		.den   (rows_q),
		.ctl   (ctl),
		.root  (root)
	);

	// hold the result word until the receiver takes it
	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT && ctl.done) begin
			mean_close <= OUT_BITS'(mean_q);
			max_high   <= OUT_BITS'(max_q);
			min_low    <= OUT_BITS'(min_q);
			std_dev    <= root[OUT_BITS-1:0];
			row_count  <= COUNT_BITS'(rows_q);
			overflow   <= drop_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= NW'(MAX_ROWS)) else $error("row count past capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !in_ready) else $error("row taken while busy");

endmodule

FILE: sim/pss_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_stats_checker
// Watches both channels, predicts each series result and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module pss_stats_checker
	import pss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [31:0]           high_price,
	input  logic [31:0]           low_price,
	input  logic [31:0]           close_price,
	input  logic                  last_row,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [OUT_BITS-1:0]   mean_close,
	input  logic [OUT_BITS-1:0]   max_high,
	input  logic [OUT_BITS-1:0]   min_low,
	input  logic [OUT_BITS-1:0]   std_dev,
	input  logic [COUNT_BITS-1:0] row_count,
	input  logic                  overflow,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [31:0]           mean;
		logic [31:0]           hi;
		logic [31:0]           lo;
		logic [31:0]           sd;
		logic [COUNT_BITS-1:0] cnt;
		logic                  ovf;
	} series_stats_t;

	logic [31:0]   closes [MAX_ROWS_DEF];
	int unsigned   n_rows;
	logic [43:0]   sum_close;
	logic [31:0]   top_high;
	logic [31:0]   bottom_low;
	logic          rows_dropped;
	series_stats_t stats_q[$];

	// Mean, then exact squared deviations, floor divide and floor square root
	function automatic series_stats_t finish_series();
		series_stats_t s;
		logic [43:0]   mean;
		logic [127:0]  acc;
		logic [127:0]  dev;
		logic [127:0]  var_q;
		logic [63:0]   root;
		logic [63:0]   t;
		mean = sum_close / n_rows;
		acc = '0;
		for (int i = 0; i < n_rows; i++) begin
			dev = (closes[i] >= mean) ? closes[i] - mean : mean - closes[i];
			acc += dev * dev;
		end
		var_q = acc / n_rows;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			t = root | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= var_q)
				root = t;
		end
		s.mean = mean[31:0];
		s.hi   = top_high;
		s.lo   = bottom_low;
		s.sd   = root[31:0];
		s.cnt  = n_rows[COUNT_BITS-1:0];
		s.ovf  = rows_dropped;
		return s;
	endfunction

	assign pending = stats_q.size();

	always @(posedge clk or negedge arst_n) begin
		series_stats_t got;
		series_stats_t exp_s;
		if (!arst_n) begin
			n_rows       = 0;
			sum_close    = '0;
			top_high     = '0;
			bottom_low   = '1;
			rows_dropped = 1'b0;
			errors       <= 0;
			stats_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				// blocking updates so the last row counts before the result
				if (n_rows < MAX_ROWS_DEF) begin
					closes[n_rows] = close_price;
					n_rows = n_rows + 1;
					sum_close = sum_close + close_price;
					if (high_price > top_high)
						top_high = high_price;
					if (low_price < bottom_low)
						bottom_low = low_price;
				end else begin
					rows_dropped = 1'b1;
				end
				if (last_row) begin
					stats_q.insert(stats_q.size(), finish_series());
					n_rows       = 0;
					sum_close    = '0;
					top_high     = '0;
					bottom_low   = '1;
					rows_dropped = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				got = {mean_close, max_high, min_low, std_dev, row_count, overflow};
				if (stats_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h",
						$time, got);
					errors <= errors + 1;
				end else begin
					exp_s = stats_q.pop_front();
					if (got != exp_s) begin
						$display("%0t: mean expected %h actual %h", $time, exp_s.mean, mean_close);
						$display("%0t: max expected %h actual %h", $time, exp_s.hi, max_high);
						$display("%0t: min expected %h actual %h", $time, exp_s.lo, min_low);
						$display("%0t: stddev expected %h actual %h", $time, exp_s.sd, std_dev);
						$display("%0t: count expected %0d actual %0d", $time, exp_s.cnt, row_count);
						$display("%0t: overflow expected %b actual %b", $time, exp_s.ovf, overflow);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

FILE: sim/tb_price_series_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_price_series_statistics
// Streams price series into the block: directed extremes, then random series
// with random idling on both sides, a long result hold-off and a drain pause.
// A checker predicts results.
// ----------------------------------------------------------------------------
module tb_price_series_statistics;
	import pss_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 600;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           high_price;
	logic [31:0]           low_price;
	logic [31:0]           close_price;
	logic                  last_row;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_BITS-1:0]   mean_close;
	logic [OUT_BITS-1:0]   max_high;
	logic [OUT_BITS-1:0]   min_low;
	logic [OUT_BITS-1:0]   std_dev;
	logic [COUNT_BITS-1:0] row_count;
	logic                  overflow;
	int                    errors;
	int                    pending;

	// Control shared between the sender and the receiver
	logic quiet;      // no idling on either side
	logic hold_req;   // ask the receiver for a long hold-off
	int   idle_cnt = 0;

	price_series_statistics i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.high_price(high_price), .low_price(low_price),
		.close_price(close_price), .last_row(last_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_close(mean_close), .max_high(max_high), .min_low(min_low),
		.std_dev(std_dev), .row_count(row_count), .overflow(overflow)
	);

	pss_stats_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.high_price(high_price), .low_price(low_price),
		.close_price(close_price), .last_row(last_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_close(mean_close), .max_high(max_high), .min_low(min_low),
		.std_dev(std_dev), .row_count(row_count), .overflow(overflow),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: count cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls, none while quiet, and one long hold-off on request
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 18);
			end
		end
	end

	// Offer one row and hold it until accepted; idle before it at random
	task automatic send_row(input logic [31:0] h, input logic [31:0] l,
			input logic [31:0] c, input logic lst);
		if (!quiet && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		high_price  <= h;
		low_price   <= l;
		close_price <= c;
		last_row    <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	// Price drawn from a mix: full range, extremes or a narrow band
	function automatic logic [31:0] pick_price(input logic [31:0] base);
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom();
			default: return base + $urandom_range(0, 32'h0004_0000);
		endcase
	endfunction

	// One random series of n rows, the last flagged
	task automatic send_series(input int n);
		logic [31:0] base;
		logic [31:0] a;
		logic [31:0] b;
		base = $urandom();
		for (int i = 0; i < n; i++) begin
			a = pick_price(base);
			b = pick_price(base);
			send_row(a > b ? a : b, a > b ? b : a, pick_price(base), i == n - 1);
		end
	endtask

	// Stop offering, let the checker see the last row, then wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int rows;
		int lim;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		high_price  = '0;
		low_price   = '0;
		close_price = '0;
		last_row    = 1'b0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single rows at the extremes, widest spread, equal rows, and series with low above high in some rows
		send_row(32'h0, 32'h0, 32'h0, 1'b1);
		send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_row(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
		send_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1);
		send_row(32'h0001_0000, 32'h0001_0000, 32'h0001_8000, 1'b0);
		send_row(32'h0001_0000, 32'h0001_0000, 32'h0001_8000, 1'b0);
		send_row(32'h0001_0000, 32'h0001_0000, 32'h0001_8000, 1'b1);
		send_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
		send_row(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
		send_row(32'h0, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1);

		// Pause the sender until every result is back
		drain();

		// Hold the receiver off while series keep coming so input stalls
		hold_req <= 1'b1;
		for (int k = 0; k < 4; k++)
			send_series($urandom_range(1, 6));

		// Random series, with a stretch free of idling
		rows = 0;
		while (rows < 700) begin
			quiet <= (rows >= 250 && rows < 400);
			case ($urandom_range(19))
				0:       lim = $urandom_range(65, 200);
				1, 2, 3: lim = $urandom_range(9, 64);
				default: lim = $urandom_range(1, 8);
			endcase
			send_series(lim);
			rows += lim;
		end
		quiet <= 1'b0;

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
